@@ src/vendor_beacon_tracking_table_top_assert.svh @@
// Assertion macros for the beacon tracking table.
// Used by vbtt_ctrl; no other dependencies.
`ifndef VENDOR_BEACON_TRACKING_TABLE_TOP_ASSERT_SVH
`define VENDOR_BEACON_TRACKING_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define VBTT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("vbtt check failed");
`define VBTT_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("vbtt check failed");
`else
`define VBTT_ASSERT(label, clk, rst, prop)
`define VBTT_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ src/vbtt_pkg.sv @@
// Shared types, codes and helpers for the beacon tracking table.
// No dependencies.
package vbtt_pkg;

  localparam int CAPACITY_DEF = 128;

  typedef struct packed {
    logic [47:0] addr;
    logic [7:0]  rssi;
    logic [2:0]  color;
    logic [31:0] seen;
  } entry_t;

  typedef struct packed {
    logic        locate_enable;
    logic [47:0] locate_address;
  } cfg_t;

  localparam logic REG_LOCATE_ENABLE  = 1'b0;
  localparam logic REG_LOCATE_ADDRESS = 1'b1;

  localparam logic [1:0] ACT_SCAN  = 2'd0;
  localparam logic [1:0] ACT_EVICT = 2'd1;

  localparam logic [3:0] ST_NOT_VENDOR = 4'd0;
  localparam logic [3:0] ST_NOT_TARGET = 4'd1;
  localparam logic [3:0] ST_FULL       = 4'd2;
  localparam logic [3:0] ST_UPDATED    = 4'd3;
  localparam logic [3:0] ST_INSERTED   = 4'd4;
  localparam logic [3:0] ST_EVICTED    = 4'd5;
  localparam logic [3:0] ST_NO_EVICT   = 4'd6;
  localparam logic [3:0] ST_READ_OK    = 4'd7;
  localparam logic [3:0] ST_READ_EMPTY = 4'd8;

  localparam logic [2:0] COL_UNKNOWN     = 3'd0;
  localparam logic [2:0] COL_GENERIC     = 3'd1;
  localparam logic [2:0] COL_BLACK       = 3'd2;
  localparam logic [2:0] COL_WHITE       = 3'd3;
  localparam logic [2:0] COL_TRANSPARENT = 3'd4;

  localparam logic [15:0] UUID_BLACK       = 16'h3081;
  localparam logic [15:0] UUID_WHITE       = 16'h3082;
  localparam logic [15:0] UUID_TRANSPARENT = 16'h3083;
  localparam logic [15:0] UUID_MASK        = 16'hFFF0;
  localparam logic [15:0] UUID_BASE        = 16'h3080;

  localparam logic [23:0] PREFIX_A = 24'h80E126;
  localparam logic [23:0] PREFIX_B = 24'h80E127;
  localparam logic [23:0] PREFIX_C = 24'h0CFA22;

  function automatic logic [2:0] classify(input logic present, input logic [15:0] uuid);
    logic [2:0] c;
    if (!present) c = COL_UNKNOWN;
    else if (uuid == UUID_BLACK) c = COL_BLACK;
    else if (uuid == UUID_WHITE) c = COL_WHITE;
    else if (uuid == UUID_TRANSPARENT) c = COL_TRANSPARENT;
    else if ((uuid & UUID_MASK) == UUID_BASE) c = COL_GENERIC;
    else c = COL_UNKNOWN;
    return c;
  endfunction

endpackage

@@ src/vbtt_mem.sv @@
// Entry store: one write port, one read port, registered read data.
// Depends on vbtt_pkg.
module vbtt_mem #(
  parameter int DEPTH = vbtt_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  vbtt_pkg::entry_t     wdata,
  input  logic [AW-1:0]        raddr,
  output vbtt_pkg::entry_t     rdata
);

  vbtt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/vbtt_ctrl.sv @@
// Sequencer: lookup, insert, insertion sort, evict copy and read over the entry store.
// Depends on vbtt_pkg and vendor_beacon_tracking_table_top_assert.svh.
`include "vendor_beacon_tracking_table_top_assert.svh"

module vbtt_ctrl #(
  parameter int CAPACITY = vbtt_pkg::CAPACITY_DEF,
  parameter int IDX_W    = $clog2(CAPACITY),
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  vbtt_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          action,
  input  logic [47:0]         device_address,
  input  logic signed [7:0]   signal_rssi,
  input  logic                uuid_present,
  input  logic [15:0]         uuid_value,
  input  logic [31:0]         now_time,
  input  logic [6:0]          read_rank,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          status,
  output logic [7:0]          entry_count,
  output logic [47:0]         entry_address,
  output logic signed [7:0]   entry_rssi,
  output logic [2:0]          entry_color,
  output logic [31:0]         entry_last_seen,
  output logic                mem_we,
  output logic [IDX_W-1:0]    mem_waddr,
  output vbtt_pkg::entry_t    mem_wdata,
  output logic [IDX_W-1:0]    mem_raddr,
  input  vbtt_pkg::entry_t    mem_rdata
);

  localparam int DROP = CAPACITY / 4;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SEARCH, S_INSERT, S_POST, S_KEY, S_CMP,
    S_PLACE, S_CSTART, S_COPY, S_READ, S_FINISH
  } state_t;

  state_t           state;
  logic [1:0]       r_act;
  logic [47:0]      r_addr;
  logic [7:0]       r_rssi;
  logic [2:0]       r_color;
  logic [31:0]      r_now;
  logic [6:0]       r_rank;
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] j;
  logic [CNT_W-1:0] count;
  logic             by_stale;
  vbtt_pkg::entry_t key;
  vbtt_pkg::entry_t res_entry;
  logic [3:0]       res_status;

  logic             full, targeted, vendor, hit, more_i, key_first, rank_ok, copy_last;
  logic [23:0]      prefix;
  vbtt_pkg::entry_t upd;
  vbtt_pkg::entry_t fresh;
  logic [IDX_W+6:0] rank_ext;
  logic [CNT_W+6:0] rank_cmp;
  logic [CNT_W+6:0] count_cmp;
  logic [CNT_W+7:0] count_ext;

  function automatic logic rssi_before(input vbtt_pkg::entry_t a, input vbtt_pkg::entry_t b);
    return $signed(a.rssi) > $signed(b.rssi);
  endfunction

  function automatic logic stale_before(input vbtt_pkg::entry_t a, input vbtt_pkg::entry_t b);
    logic r;
    if (a.seen != b.seen) r = a.seen < b.seen;
    else r = $signed(a.rssi) < $signed(b.rssi);
    return r;
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign full      = (count == CNT_W'(CAPACITY));
  assign targeted  = cfg.locate_enable && (cfg.locate_address != 48'd0);
  assign prefix    = r_addr[47:24];
  assign vendor    = (prefix == vbtt_pkg::PREFIX_A) || (prefix == vbtt_pkg::PREFIX_B) ||
                     (prefix == vbtt_pkg::PREFIX_C);
  assign hit       = (mem_rdata.addr == r_addr);
  assign more_i    = ((CNT_W'(i) + CNT_W'(1)) < count);
  assign key_first = by_stale ? stale_before(key, mem_rdata) : rssi_before(key, mem_rdata);
  assign rank_ext  = {IDX_W'(0), r_rank};
  assign rank_cmp  = {CNT_W'(0), r_rank};
  assign count_cmp = {7'd0, count};
  assign rank_ok   = (rank_cmp < count_cmp);
  assign copy_last = (i == IDX_W'(CAPACITY - DROP - 1));
  assign count_ext = {8'd0, count};

  always_comb begin
    upd = mem_rdata;
    upd.rssi = r_rssi;
    upd.seen = r_now;
    if (r_color >= vbtt_pkg::COL_BLACK) upd.color = r_color;
    fresh.addr  = r_addr;
    fresh.rssi  = r_rssi;
    fresh.color = r_color;
    fresh.seen  = r_now;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = key;
    mem_raddr = '0;
    unique case (state)
      S_DISPATCH: begin
        if (r_act == vbtt_pkg::ACT_EVICT) mem_raddr = IDX_W'(1);
        else if (r_act != vbtt_pkg::ACT_SCAN) mem_raddr = rank_ext[IDX_W-1:0];
      end
      S_SEARCH: begin
        if (hit) begin
          mem_we    = 1'b1;
          mem_waddr = i;
          mem_wdata = upd;
        end else if (more_i) begin
          mem_raddr = i + IDX_W'(1);
        end
      end
      S_INSERT: begin
        mem_we    = 1'b1;
        mem_waddr = count[IDX_W-1:0];
        mem_wdata = fresh;
      end
      S_POST: mem_raddr = IDX_W'(1);
      S_KEY: mem_raddr = i - IDX_W'(1);
      S_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = j;
        if (key_first) begin
          mem_wdata = mem_rdata;
          if (j > IDX_W'(1)) mem_raddr = j - IDX_W'(2);
        end else if (more_i) begin
          mem_raddr = i + IDX_W'(1);
        end
      end
      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        if (more_i) mem_raddr = i + IDX_W'(1);
      end
      S_CSTART: mem_raddr = IDX_W'(DROP);
      S_COPY: begin
        mem_we    = 1'b1;
        mem_waddr = i;
        mem_wdata = mem_rdata;
        if (!copy_last) mem_raddr = IDX_W'(i + IDX_W'(DROP + 1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      by_stale  <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FINISH) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            r_act   <= action;
            r_addr  <= device_address;
            r_rssi  <= signal_rssi;
            r_color <= vbtt_pkg::classify(uuid_present, uuid_value);
            r_now   <= now_time;
            r_rank  <= read_rank;
            state   <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          res_entry <= '0;
          unique case (r_act)
            vbtt_pkg::ACT_SCAN: begin
              if (!vendor) begin
                res_status <= vbtt_pkg::ST_NOT_VENDOR;
                state      <= S_FINISH;
              end else if (targeted && r_addr != cfg.locate_address) begin
                res_status <= vbtt_pkg::ST_NOT_TARGET;
                state      <= S_FINISH;
              end else if (!targeted && full) begin
                res_status <= vbtt_pkg::ST_FULL;
                state      <= S_FINISH;
              end else if (count == '0) begin
                state <= S_INSERT;
              end else begin
                i     <= '0;
                state <= S_SEARCH;
              end
            end
            vbtt_pkg::ACT_EVICT: begin
              if (full) begin
                by_stale <= 1'b1;
                i        <= IDX_W'(1);
                state    <= S_KEY;
              end else begin
                res_status <= vbtt_pkg::ST_NO_EVICT;
                state      <= S_FINISH;
              end
            end
            default: begin
              if (rank_ok) begin
                state <= S_READ;
              end else begin
                res_status <= vbtt_pkg::ST_READ_EMPTY;
                state      <= S_FINISH;
              end
            end
          endcase
        end
        S_SEARCH: begin
          if (hit) begin
            res_status <= vbtt_pkg::ST_UPDATED;
            state      <= S_POST;
          end else if (more_i) begin
            i <= i + IDX_W'(1);
          end else if (full) begin
            res_status <= vbtt_pkg::ST_FULL;
            state      <= S_FINISH;
          end else begin
            state <= S_INSERT;
          end
        end
        S_INSERT: begin
          count      <= count + CNT_W'(1);
          res_status <= vbtt_pkg::ST_INSERTED;
          state      <= S_POST;
        end
        S_POST: begin
          if (!cfg.locate_enable && count > CNT_W'(1)) begin
            by_stale <= 1'b0;
            i        <= IDX_W'(1);
            state    <= S_KEY;
          end else begin
            state <= S_FINISH;
          end
        end
        S_KEY: begin
          key   <= mem_rdata;
          j     <= i;
          state <= S_CMP;
        end
        S_CMP: begin
          if (key_first) begin
            j <= j - IDX_W'(1);
            if (j == IDX_W'(1)) state <= S_PLACE;
          end else if (more_i) begin
            i     <= i + IDX_W'(1);
            state <= S_KEY;
          end else begin
            state <= by_stale ? S_CSTART : S_FINISH;
          end
        end
        S_PLACE: begin
          if (more_i) begin
            i     <= i + IDX_W'(1);
            state <= S_KEY;
          end else begin
            state <= by_stale ? S_CSTART : S_FINISH;
          end
        end
        S_CSTART: begin
          i     <= '0;
          state <= S_COPY;
        end
        S_COPY: begin
          if (copy_last) begin
            count      <= CNT_W'(CAPACITY - DROP);
            res_status <= vbtt_pkg::ST_EVICTED;
            state      <= S_FINISH;
          end else begin
            i <= i + IDX_W'(1);
          end
        end
        S_READ: begin
          res_entry  <= mem_rdata;
          res_status <= vbtt_pkg::ST_READ_OK;
          state      <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            status          <= res_status;
            entry_count     <= count_ext[7:0];
            entry_address   <= res_entry.addr;
            entry_rssi      <= res_entry.rssi;
            entry_color     <= res_entry.color;
            entry_last_seen <= res_entry.seen;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `VBTT_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(CAPACITY))
  `VBTT_ASSERT(a_idle_no_write, clk, rst, (state == S_IDLE) |-> !mem_we)
  `VBTT_ASSERT(a_evict_count, clk, rst, (state == S_COPY && copy_last) |=> (count == CNT_W'(CAPACITY - DROP)))
  `VBTT_ASSERT(a_accept_dispatch, clk, rst, (in_valid && in_ready) |=> (state == S_DISPATCH))

endmodule

@@ src/vendor_beacon_tracking_table_top.sv @@
// Beacon tracking table top: configuration registers, sequencer and entry store.
// Depends on vbtt_pkg, vbtt_mem, vbtt_ctrl.
// A scan that passes the filters updates or inserts its entry, then, unless locate is on,
// re-sorts the table by signal strength; an evict sorts the full table by age and copies
// the rest down over the oldest quarter. One request at a time; a stalled result holds the
// sequencer. Reset clears the count, registers, handshakes.
module vendor_beacon_tracking_table_top #(
  parameter int CAPACITY = vbtt_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [47:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        action,
  input  logic [47:0]       device_address,
  input  logic signed [7:0] signal_rssi,
  input  logic              uuid_present,
  input  logic [15:0]       uuid_value,
  input  logic [31:0]       now_time,
  input  logic [6:0]        read_rank,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        status,
  output logic [7:0]        entry_count,
  output logic [47:0]       entry_address,
  output logic signed [7:0] entry_rssi,
  output logic [2:0]        entry_color,
  output logic [31:0]       entry_last_seen
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  vbtt_pkg::cfg_t   cfg;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  vbtt_pkg::entry_t mem_wdata;
  vbtt_pkg::entry_t mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        vbtt_pkg::REG_LOCATE_ENABLE:  cfg.locate_enable  <= cfg_data[0];
        vbtt_pkg::REG_LOCATE_ADDRESS: cfg.locate_address <= cfg_data;
        default: ;
      endcase
    end
  end

  vbtt_mem #(
    .DEPTH(CAPACITY),
    .AW   (IDX_W)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  vbtt_ctrl #(
    .CAPACITY(CAPACITY),
    .IDX_W   (IDX_W),
    .CNT_W   (CNT_W)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .device_address (device_address),
    .signal_rssi    (signal_rssi),
    .uuid_present   (uuid_present),
    .uuid_value     (uuid_value),
    .now_time       (now_time),
    .read_rank      (read_rank),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .entry_count    (entry_count),
    .entry_address  (entry_address),
    .entry_rssi     (entry_rssi),
    .entry_color    (entry_color),
    .entry_last_seen(entry_last_seen),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

endmodule

@@ bench/vendor_beacon_tracking_table_top_test.sv @@
// Self-checking bench for the vendor beacon tracking table: a directed table of requests,
// then random scan/evict/read traffic over several locate settings, scored by a predictor.
// Depends on vbtt_pkg and vendor_beacon_tracking_table_top.
module vendor_beacon_tracking_table_top_test;

  localparam int DEPTH = vbtt_pkg::CAPACITY_DEF;
  localparam logic [1:0] ACT_READ = 2'd2;
  localparam logic [1:0] ACT_READ_ALT = 2'd3;
  localparam longint CYCLE_LIMIT = 40_000_000;

  typedef struct {
    logic [1:0]        action;
    logic [47:0]       addr;
    logic signed [7:0] rssi;
    logic              present;
    logic [15:0]       uuid;
    logic [31:0]       now;
    logic [6:0]        rank;
  } req_t;

  typedef struct {
    logic [3:0]        status;
    logic [7:0]        count;
    logic [47:0]       addr;
    logic signed [7:0] rssi;
    logic [2:0]        color;
    logic [31:0]       seen;
  } outcome_t;

  typedef struct {
    req_t       req;
    bit         typed;
    logic [3:0] status;
    logic [7:0] count;
  } row_t;

  logic clk, rst;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [47:0] cfg_data;
  logic in_valid, in_ready;
  logic [1:0] action;
  logic [47:0] device_address;
  logic signed [7:0] signal_rssi;
  logic uuid_present;
  logic [15:0] uuid_value;
  logic [31:0] now_time;
  logic [6:0] read_rank;
  logic out_valid, out_ready;
  logic [3:0] status;
  logic [7:0] entry_count;
  logic [47:0] entry_address;
  logic signed [7:0] entry_rssi;
  logic [2:0] entry_color;
  logic [31:0] entry_last_seen;

  vendor_beacon_tracking_table_top uut (.*);

  // predictor state
  vbtt_pkg::entry_t track[DEPTH];
  int         tracked;
  logic       mirror_locate;
  logic [47:0] mirror_target;

  outcome_t   pending[$];
  row_t       rows[$];
  int         errors;
  longint     cycles;
  int         stall_left;
  bit         steady;
  logic [47:0] pool[200];
  logic [31:0] clock_ms;

  function automatic logic [2:0] color_of(logic present, logic [15:0] uuid);
    if (!present) return vbtt_pkg::COL_UNKNOWN;
    case (uuid)
      vbtt_pkg::UUID_BLACK:       return vbtt_pkg::COL_BLACK;
      vbtt_pkg::UUID_WHITE:       return vbtt_pkg::COL_WHITE;
      vbtt_pkg::UUID_TRANSPARENT: return vbtt_pkg::COL_TRANSPARENT;
      default: return (uuid[15:4] == vbtt_pkg::UUID_BASE[15:4]) ? vbtt_pkg::COL_GENERIC
                                                                 : vbtt_pkg::COL_UNKNOWN;
    endcase
  endfunction

  function automatic bit goes_first(vbtt_pkg::entry_t a, vbtt_pkg::entry_t b, bit by_age);
    if (!by_age) return $signed(a.rssi) > $signed(b.rssi);
    if (a.seen != b.seen) return a.seen < b.seen;
    return $signed(a.rssi) < $signed(b.rssi);
  endfunction

  function automatic void reorder(bit by_age);
    vbtt_pkg::entry_t key;
    int j;
    for (int i = 1; i < tracked; i++) begin
      key = track[i];
      j = i;
      while (j > 0 && goes_first(key, track[j-1], by_age)) begin
        track[j] = track[j-1];
        j--;
      end
      track[j] = key;
    end
  endfunction

  function automatic outcome_t track_request(req_t r);
    outcome_t o;
    logic [2:0] col;
    bit targeted, found;
    o = '{default: '0};
    col = color_of(r.present, r.uuid);
    targeted = mirror_locate && mirror_target != 0;
    if (r.action == vbtt_pkg::ACT_SCAN) begin
      if (!(r.addr[47:24] inside {vbtt_pkg::PREFIX_A, vbtt_pkg::PREFIX_B, vbtt_pkg::PREFIX_C}))
        o.status = vbtt_pkg::ST_NOT_VENDOR;
      else if (targeted && r.addr != mirror_target) o.status = vbtt_pkg::ST_NOT_TARGET;
      else if (!targeted && tracked >= DEPTH) o.status = vbtt_pkg::ST_FULL;
      else begin
        found = 0;
        for (int i = 0; i < tracked && !found; i++)
          if (track[i].addr == r.addr) begin
            track[i].rssi = r.rssi;
            track[i].seen = r.now;
            if (col >= vbtt_pkg::COL_BLACK) track[i].color = col;
            found = 1;
          end
        if (found) o.status = vbtt_pkg::ST_UPDATED;
        else if (tracked >= DEPTH) o.status = vbtt_pkg::ST_FULL;
        else begin
          track[tracked] = '{addr: r.addr, rssi: r.rssi, color: col, seen: r.now};
          tracked++;
          o.status = vbtt_pkg::ST_INSERTED;
        end
        if (o.status != vbtt_pkg::ST_FULL && !mirror_locate) reorder(0);
      end
    end else if (r.action == vbtt_pkg::ACT_EVICT) begin
      if (tracked >= DEPTH) begin
        reorder(1);
        for (int i = 0; i < DEPTH - DEPTH/4; i++) track[i] = track[i + DEPTH/4];
        tracked = DEPTH - DEPTH/4;
        o.status = vbtt_pkg::ST_EVICTED;
      end else o.status = vbtt_pkg::ST_NO_EVICT;
    end else begin
      if (r.rank < tracked) begin
        o.status = vbtt_pkg::ST_READ_OK;
        o.addr = track[r.rank].addr;
        o.rssi = track[r.rank].rssi;
        o.color = track[r.rank].color;
        o.seen = track[r.rank].seen;
      end else o.status = vbtt_pkg::ST_READ_EMPTY;
    end
    o.count = tracked[7:0];
    return o;
  endfunction

  function automatic int pick_gap();
    int p;
    if (steady) return 0;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  function automatic void add_row(req_t r, bit typed, logic [3:0] st, logic [7:0] cnt);
    row_t w;
    w.req = r;
    w.typed = typed;
    w.status = st;
    w.count = cnt;
    rows.insert(rows.size(), w);
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** vendor_beacon_tracking_table_top: FAILED **");
      $finish;
    end
  end

  // result checker and receiver stalls
  always @(posedge clk) begin
    outcome_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        $error("unexpected result status=%0d", status);
        errors++;
      end else begin
        e = pending.pop_front();
        if (status !== e.status) begin
          $error("status exp %0d got %0d", e.status, status); errors++;
        end
        if (entry_count !== e.count) begin
          $error("entry_count exp %0d got %0d", e.count, entry_count); errors++;
        end
        if (entry_address !== e.addr) begin
          $error("entry_address exp %h got %h", e.addr, entry_address); errors++;
        end
        if (entry_rssi !== e.rssi) begin
          $error("entry_rssi exp %0d got %0d", e.rssi, entry_rssi); errors++;
        end
        if (entry_color !== e.color) begin
          $error("entry_color exp %0d got %0d", e.color, entry_color); errors++;
        end
        if (entry_last_seen !== e.seen) begin
          $error("entry_last_seen exp %h got %h", e.seen, entry_last_seen); errors++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 0;
    end else begin
      out_ready <= 1;
      if (!steady && $urandom_range(99) < 25)
        stall_left <= ($urandom_range(9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
    end
  end

  task automatic send_request(req_t r, bit typed, logic [3:0] st, logic [7:0] cnt);
    int g;
    outcome_t o;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    action <= r.action;
    device_address <= r.addr;
    signal_rssi <= r.rssi;
    uuid_present <= r.present;
    uuid_value <= r.uuid;
    now_time <= r.now;
    read_rank <= r.rank;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    o = track_request(r);
    if (typed) begin
      o.status = st;
      o.count = cnt;
    end
    pending.insert(pending.size(), o);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [47:0] value);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    if (idx == vbtt_pkg::REG_LOCATE_ENABLE) mirror_locate = value[0];
    else mirror_target = value;
    @(posedge clk);
  endtask

  function automatic req_t random_request(int target_share, logic [47:0] target);
    req_t r;
    int p;
    r.action = vbtt_pkg::ACT_SCAN;
    r.addr = pool[$urandom_range(199)];
    r.rssi = 8'($urandom_range(255));
    r.present = $urandom_range(3) != 0;
    p = $urandom_range(9);
    r.uuid = (p < 7) ? {12'h308, 4'($urandom_range(15))} : 16'($urandom);
    clock_ms = clock_ms + 32'($urandom_range(3));
    r.now = ($urandom_range(19) == 0) ? $urandom : clock_ms;
    r.rank = (tracked > 0 && $urandom_range(4) != 0) ? 7'($urandom_range(tracked - 1))
                                                      : 7'($urandom_range(127));
    p = $urandom_range(99);
    if (p < 8) begin
      r.action = 2'($urandom_range(3));
      r.addr = {16'($urandom), 32'($urandom)};
    end else if (p < 18) r.action = vbtt_pkg::ACT_EVICT;
    else if (p < 32) r.action = ($urandom_range(4) == 0) ? ACT_READ_ALT : ACT_READ;
    else if ($urandom_range(99) < target_share) r.addr = target;
    return r;
  endfunction

  initial begin
    logic [47:0] a1, a2, a3, tgt;
    errors = 0;
    cycles = 0;
    stall_left = 0;
    steady = 0;
    tracked = 0;
    mirror_locate = 0;
    mirror_target = 0;
    clock_ms = 32'h1000;
    tgt = 48'h0;
    rst <= 1;
    cfg_valid <= 0; cfg_index <= 0; cfg_data <= 0;
    in_valid <= 0; action <= 0; device_address <= 0; signal_rssi <= 0;
    uuid_present <= 0; uuid_value <= 0; now_time <= 0; read_rank <= 0;
    out_ready <= 0;
    for (int i = 0; i < 200; i++)
      case (i % 3)
        0: pool[i] = {vbtt_pkg::PREFIX_A, 24'($urandom)};
        1: pool[i] = {vbtt_pkg::PREFIX_B, 24'($urandom)};
        default: pool[i] = {vbtt_pkg::PREFIX_C, 24'($urandom)};
      endcase
    a1 = {vbtt_pkg::PREFIX_A, 24'h000000};
    a2 = {vbtt_pkg::PREFIX_B, 24'hFFFFFF};
    a3 = {vbtt_pkg::PREFIX_C, 24'h5A5A5A};
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    //        action              addr            rssi    pres  uuid    now    rank
    add_row('{ACT_READ, 48'h0, 8'sd0, 1'b0, 16'h0, 32'h0, 7'd0}, 1'b1,
            vbtt_pkg::ST_READ_EMPTY, 8'd0);
    add_row('{vbtt_pkg::ACT_EVICT, 48'h0, 8'sd0, 1'b0, 16'h0, 32'h0, 7'd0}, 1'b1,
            vbtt_pkg::ST_NO_EVICT, 8'd0);
    add_row('{vbtt_pkg::ACT_SCAN, 48'hFFFFFFFFFFFF, 8'sd5, 1'b1, vbtt_pkg::UUID_BLACK,
              32'h1, 7'd0}, 1'b1, vbtt_pkg::ST_NOT_VENDOR, 8'd0);
    add_row('{vbtt_pkg::ACT_SCAN, a1, 8'sd127, 1'b1, vbtt_pkg::UUID_BLACK, 32'h0, 7'd0},
            1'b1, vbtt_pkg::ST_INSERTED, 8'd1);
    add_row('{vbtt_pkg::ACT_SCAN, a2, -8'sd128, 1'b0, vbtt_pkg::UUID_WHITE, 32'hFFFFFFFF,
              7'd0}, 1'b1, vbtt_pkg::ST_INSERTED, 8'd2);
    add_row('{vbtt_pkg::ACT_SCAN, a3, 8'sd0, 1'b1, vbtt_pkg::UUID_WHITE, 32'h10, 7'd0},
            1'b1, vbtt_pkg::ST_INSERTED, 8'd3);
    add_row('{vbtt_pkg::ACT_SCAN, {vbtt_pkg::PREFIX_A, 24'h1}, -8'sd1, 1'b1,
              vbtt_pkg::UUID_TRANSPARENT, 32'h11, 7'd0}, 1'b1, vbtt_pkg::ST_INSERTED, 8'd4);
    add_row('{vbtt_pkg::ACT_SCAN, {vbtt_pkg::PREFIX_B, 24'h2}, 8'sd0, 1'b1, 16'h308F,
              32'h12, 7'd0}, 1'b1, vbtt_pkg::ST_INSERTED, 8'd5);
    add_row('{vbtt_pkg::ACT_SCAN, {vbtt_pkg::PREFIX_C, 24'h3}, 8'sd0, 1'b1, 16'hFFFF,
              32'h12, 7'd0}, 1'b1, vbtt_pkg::ST_INSERTED, 8'd6);
    add_row('{vbtt_pkg::ACT_SCAN, {vbtt_pkg::PREFIX_C, 24'h4}, 8'sd3, 1'b1, 16'h3080,
              32'h13, 7'd0}, 1'b1, vbtt_pkg::ST_INSERTED, 8'd7);
    add_row('{vbtt_pkg::ACT_SCAN, a1, -8'sd20, 1'b1, 16'h3085, 32'h20, 7'd0},
            1'b1, vbtt_pkg::ST_UPDATED, 8'd7);
    add_row('{vbtt_pkg::ACT_SCAN, a2, 8'sd40, 1'b1, vbtt_pkg::UUID_TRANSPARENT, 32'h21,
              7'd0}, 1'b1, vbtt_pkg::ST_UPDATED, 8'd7);
    add_row('{vbtt_pkg::ACT_SCAN, a3, 8'sd40, 1'b0, 16'h0, 32'h22, 7'd0},
            1'b1, vbtt_pkg::ST_UPDATED, 8'd7);
    add_row('{vbtt_pkg::ACT_SCAN, {24'h80E128, 24'h0}, 8'sd1, 1'b1, 16'h3081, 32'h23, 7'd0},
            1'b1, vbtt_pkg::ST_NOT_VENDOR, 8'd7);
    for (int k = 0; k < 7; k++)
      add_row('{(k == 3) ? ACT_READ_ALT : ACT_READ, 48'h0, 8'sd0, 1'b0, 16'h0, 32'h0,
                7'(k)}, 1'b0, 4'd0, 8'd0);
    add_row('{ACT_READ, 48'h0, 8'sd0, 1'b0, 16'h0, 32'h0, 7'd7}, 1'b1,
            vbtt_pkg::ST_READ_EMPTY, 8'd7);
    add_row('{ACT_READ, 48'h0, 8'sd0, 1'b0, 16'h0, 32'h0, 7'd127}, 1'b1,
            vbtt_pkg::ST_READ_EMPTY, 8'd7);
    foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].status, rows[i].count);
    drain();

    // phases: sorted tracking, then locate on a pool target, zero target,
    // an all-ones target, and back to sorted tracking
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin
          tgt = pool[$urandom_range(199)];
          write_reg(vbtt_pkg::REG_LOCATE_ADDRESS, tgt);
          write_reg(vbtt_pkg::REG_LOCATE_ENABLE, 48'h1);
        end
        2: write_reg(vbtt_pkg::REG_LOCATE_ADDRESS, 48'h0);
        3: write_reg(vbtt_pkg::REG_LOCATE_ADDRESS, 48'hFFFFFFFFFFFF);
        4: begin
          write_reg(vbtt_pkg::REG_LOCATE_ENABLE, 48'h0);
          write_reg(vbtt_pkg::REG_LOCATE_ADDRESS, 48'h0);
        end
        default: ;
      endcase
      for (int n = 0; n < ((ph == 0) ? 450 : 175); n++) begin
        if (n % 100 == 0) steady = ($urandom_range(3) == 0);
        send_request(random_request((ph == 1) ? 40 : 0, tgt), 1'b0, 4'd0, 8'd0);
      end
      steady = 0;
      drain();
    end

    if (errors == 0)
      $display("** vendor_beacon_tracking_table_top: PASSED **");
    else
      $display("** vendor_beacon_tracking_table_top: FAILED **");
    $finish;
  end

endmodule
